// ===== rtl/kpm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpm_pkg
// Shared types and constants of the streaming KMP pattern matcher.
// ----------------------------------------------------------------------------
package kpm_pkg;

  localparam int PatternMax = 64;
  localparam int PtrBits    = $clog2(PatternMax);
  localparam int LenBits    = PtrBits + 1;
  localparam int PosBits    = 32;
  localparam int OutBits    = 32;
  localparam int SymBits    = 8;
  localparam int CmdBits    = 2;

  typedef logic [PtrBits-1:0] ptr_t;
  typedef logic [LenBits-1:0] len_t;
  typedef logic [PosBits-1:0] pos_t;
  typedef logic [SymBits-1:0] sym_t;

  typedef enum logic [CmdBits-1:0] {
    CmdClear   = 2'd0,
    CmdAppend  = 2'd1,
    CmdNewText = 2'd2,
    CmdText    = 2'd3
  } cmd_e;

  // table index of the border for a prefix of length len
  function automatic ptr_t prev_ptr(input len_t len);
    len_t dec;
    dec = len - len_t'(1);
    return dec[PtrBits-1:0];
  endfunction

endpackage

// ===== rtl/kmp_pattern_matcher_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmp_pattern_matcher_core
// Byte-stream Knuth-Morris-Pratt matcher with incremental failure table.
//
//   channel   dir  tdata                     tuser
//   s_axis    in   [7:0] symbol              [1:0] command
//   m_axis    out  [31:0] match_start        -
//
// Pattern and border table sit in two synchronous RAMs with registered reads.
// Clear, new-text, ignored and first appends finish in StIdle; other appends
// pass StFetch and StLook, text bytes StLook (not with an empty pattern),
// plus one border-table read per failure-link fallback. A match waits in an
// output register while the next item is taken; only a second match stalls
// until it is taken. Reset clears lengths and position; RAMs need no clearing.
// ----------------------------------------------------------------------------
module kmp_pattern_matcher_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] symbol
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] command
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o    // [31:0] match_start
);

  typedef enum logic [1:0] {
    StIdle,
    StFetch,
    StLook
  } state_e;

  state_e             state_q, state_d;
  kpm_pkg::len_t      plen_q, plen_d;
  kpm_pkg::len_t      mlen_q, mlen_d;
  kpm_pkg::len_t      len_q, len_d;
  kpm_pkg::pos_t      pos_q, pos_d;
  kpm_pkg::sym_t      sym_q, sym_d;
  logic               append_q, append_d;
  logic               out_valid_q, out_valid_d;
  logic [kpm_pkg::OutBits-1:0] out_data_q, out_data_d;

  kpm_pkg::sym_t      pat_mem [kpm_pkg::PatternMax];
  kpm_pkg::len_t      brd_mem [kpm_pkg::PatternMax];
  kpm_pkg::sym_t      p_rdata_q;
  kpm_pkg::len_t      b_rdata_q;

  logic               rd_en;
  kpm_pkg::ptr_t      p_raddr, b_raddr;
  logic               p_we, b_we;
  kpm_pkg::ptr_t      b_waddr;
  kpm_pkg::len_t      b_wdata;

  logic               step_hit, finish, out_free;
  kpm_pkg::len_t      next_len;
  kpm_pkg::pos_t      start_pos;
  kpm_pkg::cmd_e      cmd;

  assign cmd             = kpm_pkg::cmd_e'(s_axis_tuser_i);
  assign s_axis_tready_o = (state_q == StIdle);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  assign step_hit  = (p_rdata_q == sym_q);
  assign finish    = step_hit || (len_q == '0);
  assign next_len  = step_hit ? (len_q + kpm_pkg::len_t'(1)) :
                     ((len_q == '0) ? '0 : b_rdata_q);
  assign out_free  = !out_valid_q || m_axis_tready_i;
  assign start_pos = pos_q - kpm_pkg::pos_t'(plen_q) + kpm_pkg::pos_t'(1);

  // pattern and border memories
  always_ff @(posedge clk_i) begin
    if (p_we) begin
      pat_mem[plen_q[kpm_pkg::PtrBits-1:0]] <= s_axis_tdata_i;
    end
    if (rd_en) begin
      p_rdata_q <= pat_mem[p_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_we) begin
      brd_mem[b_waddr] <= b_wdata;
    end
    if (rd_en) begin
      b_rdata_q <= brd_mem[b_raddr];
    end
  end

  always_comb begin
    state_d     = state_q;
    plen_d      = plen_q;
    mlen_d      = mlen_q;
    len_d       = len_q;
    pos_d       = pos_q;
    sym_d       = sym_q;
    append_d    = append_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    rd_en       = 1'b0;
    p_raddr     = len_q[kpm_pkg::PtrBits-1:0];
    b_raddr     = kpm_pkg::prev_ptr(len_q);
    p_we        = 1'b0;
    b_we        = 1'b0;
    b_waddr     = plen_q[kpm_pkg::PtrBits-1:0];
    b_wdata     = next_len;

    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (s_axis_tvalid_i) begin
          sym_d = s_axis_tdata_i;
          unique case (cmd)
            kpm_pkg::CmdClear: begin
              plen_d = '0;
              mlen_d = '0;
            end
            kpm_pkg::CmdAppend: begin
              if (plen_q != kpm_pkg::len_t'(kpm_pkg::PatternMax)) begin
                p_we = 1'b1;
                if (plen_q == '0) begin
                  b_we    = 1'b1;
                  b_wdata = '0;
                  plen_d  = kpm_pkg::len_t'(1);
                end else begin
                  rd_en    = 1'b1;
                  b_raddr  = kpm_pkg::prev_ptr(plen_q);
                  append_d = 1'b1;
                  state_d  = StFetch;
                end
              end
            end
            kpm_pkg::CmdNewText: begin
              mlen_d = '0;
              pos_d  = '0;
            end
            kpm_pkg::CmdText: begin
              pos_d = pos_q + kpm_pkg::pos_t'(1);
              if (plen_q == '0) begin
                mlen_d = '0;
              end else begin
                rd_en    = 1'b1;
                p_raddr  = mlen_q[kpm_pkg::PtrBits-1:0];
                b_raddr  = kpm_pkg::prev_ptr(mlen_q);
                len_d    = mlen_q;
                append_d = 1'b0;
                state_d  = StLook;
              end
            end
            default: ;
          endcase
        end
      end
      StFetch: begin
        rd_en   = 1'b1;
        p_raddr = b_rdata_q[kpm_pkg::PtrBits-1:0];
        b_raddr = kpm_pkg::prev_ptr(b_rdata_q);
        len_d   = b_rdata_q;
        state_d = StLook;
      end
      StLook: begin
        if (finish) begin
          if (append_q) begin
            b_we    = 1'b1;
            plen_d  = plen_q + kpm_pkg::len_t'(1);
            state_d = StIdle;
          end else if (next_len >= plen_q) begin
            // full match, held until the output register is free
            if (out_free) begin
              out_valid_d = 1'b1;
              out_data_d  = start_pos[kpm_pkg::OutBits-1:0];
              mlen_d      = '0;
              state_d     = StIdle;
            end
          end else begin
            mlen_d  = next_len;
            state_d = StIdle;
          end
        end else begin
          // mismatch: follow the failure link
          rd_en   = 1'b1;
          p_raddr = b_rdata_q[kpm_pkg::PtrBits-1:0];
          b_raddr = kpm_pkg::prev_ptr(b_rdata_q);
          len_d   = b_rdata_q;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      plen_q      <= '0;
      mlen_q      <= '0;
      len_q       <= '0;
      pos_q       <= '0;
      append_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      plen_q      <= plen_d;
      mlen_q      <= mlen_d;
      len_q       <= len_d;
      pos_q       <= pos_d;
      append_q    <= append_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sym_q      <= sym_d;
    out_data_q <= out_data_d;
  end

endmodule

// ===== dv/kmp_pattern_matcher_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmp_pattern_matcher_core_tb
// Self-checking bench for the streaming KMP matcher. A behavioral model of
// the pattern store, border table, matched length and text position predicts
// every match start. Directed tests cover the empty pattern, match without
// overlap, append during text, clear, and the full pattern. A long output
// hold-off fills the block and stalls its input. Random pattern/text
// sequences with noise then run under random idling on both sides.
// ----------------------------------------------------------------------------
module kmp_pattern_matcher_core_tb;
  import kpm_pkg::*;

  localparam int CycleLimit = 1000000;
  localparam int DrainCycles = 100;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i;   // [7:0] symbol
  logic [1:0]  s_axis_tuser_i;   // [1:0] command
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [31:0] m_axis_tdata_o;   // [31:0] match_start

  kmp_pattern_matcher_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  // predictor state
  sym_t pattern_mem [PatternMax];
  len_t border_mem  [PatternMax];
  len_t pat_len;
  len_t match_len;
  pos_t text_pos;

  logic [31:0] expected_starts [$];

  int idle_max;
  int stall_left;
  int hold_left;
  int items_sent;
  int mismatches;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("%0t: timeout, %0d match starts still expected", $time, expected_starts.size());
    $display("FAIL kmp_pattern_matcher_core");
    $finish;
  end

  // longest prefix match after one more text byte
  function automatic len_t step_match(len_t len, sym_t c);
    len_t l;
    l = len;
    while (l > 0 && l < PatternMax && pattern_mem[l] != c) l = border_mem[l - 1];
    if (l < PatternMax && pattern_mem[l] == c) l = l + len_t'(1);
    return l;
  endfunction

  task automatic append_symbol(sym_t c);
    len_t k;
    if (pat_len >= PatternMax) return;
    pattern_mem[pat_len] = c;
    if (pat_len == 0) begin
      border_mem[0] = '0;
    end else begin
      k = border_mem[pat_len - 1];
      while (k > 0 && pattern_mem[k] != c) k = border_mem[k - 1];
      if (pattern_mem[k] == c && k < pat_len) k = k + len_t'(1);
      border_mem[pat_len] = k;
    end
    pat_len = pat_len + len_t'(1);
  endtask

  task automatic predict_match(cmd_e cmd, sym_t sym);
    case (cmd)
      CmdClear: begin
        pat_len = '0;
        match_len = '0;
      end
      CmdAppend: begin
        append_symbol(sym);
      end
      CmdNewText: begin
        match_len = '0;
        text_pos = '0;
      end
      default: begin
        text_pos = text_pos + pos_t'(1);
        if (pat_len == 0) begin
          match_len = '0;
        end else begin
          match_len = step_match(match_len, sym);
          if (match_len >= pat_len) begin
            match_len = '0;
            expected_starts.push_back(32'(text_pos - pos_t'(pat_len) + pos_t'(1)));
          end
        end
      end
    endcase
  endtask

  // called at a falling edge, returns at a falling edge
  task automatic send_item(cmd_e cmd, sym_t sym);
    int gap;
    gap = (idle_max == 0) ? 0 : $urandom_range(idle_max, 0);
    if (gap > 0) begin
      s_axis_tvalid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i  = sym;
    s_axis_tuser_i  = cmd;
    do @(posedge clk_i); while (!s_axis_tready_o);
    predict_match(cmd, sym);
    items_sent++;
    @(negedge clk_i);
  endtask

  // receiver: long hold-off first, then the per-item stall
  initial begin
    m_axis_tready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        m_axis_tready_i = 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        m_axis_tready_i = 1'b0;
        stall_left--;
      end else begin
        m_axis_tready_i = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_starts.size() == 0) begin
        $display("%0t: unexpected match_start, expected none, actual %0d",
                 $time, m_axis_tdata_o);
        mismatches++;
      end else if (expected_starts[0] !== m_axis_tdata_o) begin
        $display("%0t: match_start mismatch, expected %0d, actual %0d",
                 $time, expected_starts[0], m_axis_tdata_o);
        mismatches++;
        void'(expected_starts.pop_front());
      end else begin
        void'(expected_starts.pop_front());
      end
      stall_left = (idle_max == 0) ? 0 : $urandom_range(idle_max, 0);
    end
  end

  task automatic test_empty_pattern();
    send_item(CmdClear, 8'hFF);
    send_item(CmdNewText, 8'h00);
    send_item(CmdText, 8'h00);
    send_item(CmdText, 8'hFF);
    send_item(CmdText, 8'hA5);
  endtask

  task automatic test_match_no_overlap();
    send_item(CmdAppend, 8'h00);
    send_item(CmdAppend, 8'hFF);
    send_item(CmdAppend, 8'h00);
    send_item(CmdNewText, 8'hFF);
    send_item(CmdText, 8'h00);
    send_item(CmdText, 8'hFF);
    send_item(CmdText, 8'h00);
    send_item(CmdText, 8'hFF);
    send_item(CmdText, 8'h00);
    send_item(CmdText, 8'hFF);
    send_item(CmdText, 8'h00);
  endtask

  task automatic test_append_during_text();
    send_item(CmdText, 8'h00);
    send_item(CmdText, 8'hFF);
    send_item(CmdAppend, 8'h55);
    send_item(CmdText, 8'h00);
    send_item(CmdText, 8'h55);
  endtask

  // position survives a clear
  task automatic test_clear_keeps_position();
    send_item(CmdClear, 8'h00);
    send_item(CmdAppend, 8'h5A);
    send_item(CmdText, 8'h5A);
  endtask

  // the append past capacity is dropped
  task automatic test_pattern_full();
    send_item(CmdClear, 8'h00);
    for (int i = 0; i < PatternMax; i++) send_item(CmdAppend, (i == 40) ? 8'h02 : 8'h01);
    send_item(CmdAppend, 8'hFE);
    send_item(CmdNewText, 8'h00);
    for (int i = 0; i < 2 * PatternMax + 45; i++)
      send_item(CmdText, (i == 40 || i == 104) ? 8'h02 : 8'h01);
    send_item(CmdText, 8'hFE);
  endtask

  task automatic test_output_backpressure();
    idle_max = 0;
    send_item(CmdClear, 8'h00);
    send_item(CmdAppend, 8'h77);
    send_item(CmdNewText, 8'h00);
    hold_left = 300;
    for (int i = 0; i < 40; i++) send_item(CmdText, 8'h77);
    idle_max = 16;
  endtask

  task automatic test_random_sequences(int n_items);
    int   first;
    int   plen;
    int   alpha;
    int   tlen;
    int   r;
    sym_t base;
    sym_t pat [PatternMax];
    first = items_sent;
    while (items_sent - first < n_items) begin
      idle_max = ($urandom_range(3, 0) == 0) ? 0 : 16;
      if ($urandom_range(9, 0) == 0) begin
        // noise
        for (int i = 0; i < 8; i++)
          send_item(cmd_e'($urandom_range(3, 0)), sym_t'($urandom_range(255, 0)));
      end else begin
        base  = sym_t'($urandom_range(255, 0));
        alpha = $urandom_range(3, 1);
        plen  = ($urandom_range(15, 0) == 0) ? $urandom_range(PatternMax, 20)
                                             : $urandom_range(6, 1);
        for (int i = 0; i < plen; i++) pat[i] = base + sym_t'($urandom_range(alpha - 1, 0));
        if ($urandom_range(7, 0) != 0) send_item(CmdClear, sym_t'($urandom_range(255, 0)));
        for (int i = 0; i < plen; i++) send_item(CmdAppend, pat[i]);
        if ($urandom_range(5, 0) != 0) send_item(CmdNewText, sym_t'($urandom_range(255, 0)));
        tlen = $urandom_range(30, 5);
        for (int i = 0; i < tlen; i++) begin
          r = $urandom_range(39, 0);
          if (r < 4) begin
            for (int j = 0; j < plen; j++) send_item(CmdText, pat[j]);
          end else if (r == 4) begin
            send_item(CmdAppend, base + sym_t'($urandom_range(alpha - 1, 0)));
          end else if (r == 5) begin
            send_item(CmdText, sym_t'($urandom_range(255, 0)));
          end else begin
            send_item(CmdText, base + sym_t'($urandom_range(alpha - 1, 0)));
          end
        end
      end
    end
    idle_max = 16;
  endtask

  initial begin
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = CmdClear;
    pat_len         = '0;
    match_len       = '0;
    text_pos        = '0;
    idle_max        = 16;
    stall_left      = 0;
    hold_left       = 0;
    items_sent      = 0;
    mismatches      = 0;
    for (int i = 0; i < PatternMax; i++) begin
      pattern_mem[i] = '0;
      border_mem[i]  = '0;
    end
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_empty_pattern();
    test_match_no_overlap();
    test_append_during_text();
    test_clear_keeps_position();
    test_pattern_full();
    test_output_backpressure();
    test_random_sequences(540);

    s_axis_tvalid_i = 1'b0;
    while (expected_starts.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS kmp_pattern_matcher_core");
    end else begin
      $display("FAIL kmp_pattern_matcher_core");
    end
    $finish;
  end

endmodule
